// File: design/fcf_pkg.sv
// Shared types and constants of the foreground centroid finder.
// No dependencies; used by every other file of the block.
package fcf_pkg;

    localparam int PIX_W   = 8;
    localparam int CFG_W   = 11;
    localparam int COORD_W = 10;
    localparam int SUM_W   = 40;
    localparam int COUNT_W = 21;

    localparam logic [PIX_W-1:0]   BACKGROUND  = 8'hFF;
    localparam logic [COUNT_W-1:0] COUNT_MAX   = {COUNT_W{1'b1}};
    localparam logic [CFG_W-1:0]   WIDTH_RESET = 11'd640;

    // one quotient bit per step over the rounded dividend
    localparam int DIV_STEPS   = SUM_W + 1;
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [SUM_W-1:0]   col_sum;
        logic [SUM_W-1:0]   row_sum;
        logic [COUNT_W-1:0] count;
    } t_frame_sums;

    typedef struct packed {
        logic full;
        logic not_empty;
    } t_q_status;

endpackage

// File: design/fcf_front.sv
// Front end: accepts pixels, tracks column and row, accumulates the frame sums.
// Pushes the finished totals of a frame into the queue. Depends on fcf_pkg.
module fcf_front #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [fcf_pkg::CFG_W-1:0]           i_cfg_wdata,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [fcf_pkg::PIX_W-1:0]           i_pixel_value,
    input  logic                                i_last_pixel,
    input  logic                                i_q_full,
    output logic                                o_push,
    output fcf_pkg::t_frame_sums                o_push_data
);

    localparam int CW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int EW  = (WW > fcf_pkg::CFG_W) ? WW : fcf_pkg::CFG_W;
    localparam int SW  = fcf_pkg::SUM_W;
    localparam int NW  = fcf_pkg::COUNT_W;

    logic [fcf_pkg::CFG_W-1:0] r_width;
    logic [CW-1:0]             r_column, n_column;
    logic [RW-1:0]             r_row, n_row;
    logic [SW-1:0]             r_col_sum, n_col_sum;
    logic [SW-1:0]             r_row_sum, n_row_sum;
    logic [NW-1:0]             r_count, n_count;

    logic          accept;
    logic          hit;
    logic [EW-1:0] width_ext;
    logic [EW-1:0] width_eff;
    logic [EW-1:0] col_inc;
    logic          wrap;
    logic [SW-1:0] sum_c;
    logic [SW-1:0] sum_r;
    logic [NW-1:0] cnt;

    assign o_ready = ~i_q_full;
    assign accept  = i_valid & ~i_q_full;

    // clamp the configured width into 1..MAX_WIDTH
    always_comb begin
        width_ext = EW'(r_width);
        if (r_width == '0) begin
            width_eff = EW'(1);
        end else if (width_ext > EW'(MAX_WIDTH)) begin
            width_eff = EW'(MAX_WIDTH);
        end else begin
            width_eff = width_ext;
        end
    end

    assign col_inc = EW'(r_column) + EW'(1);
    assign wrap    = col_inc >= width_eff;

    assign hit   = (i_pixel_value != fcf_pkg::BACKGROUND) && (r_count != fcf_pkg::COUNT_MAX);
    assign sum_c = hit ? r_col_sum + SW'(r_column) : r_col_sum;
    assign sum_r = hit ? r_row_sum + SW'(r_row) : r_row_sum;
    assign cnt   = hit ? r_count + NW'(1) : r_count;

    assign o_push              = accept & i_last_pixel;
    assign o_push_data.col_sum = sum_c;
    assign o_push_data.row_sum = sum_r;
    assign o_push_data.count   = cnt;

    always_comb begin
        n_column  = r_column;
        n_row     = r_row;
        n_col_sum = r_col_sum;
        n_row_sum = r_row_sum;
        n_count   = r_count;
        if (accept) begin
            if (i_last_pixel) begin
                // hand the totals over and start the next frame afresh
                n_column  = '0;
                n_row     = '0;
                n_col_sum = '0;
                n_row_sum = '0;
                n_count   = '0;
            end else begin
                n_col_sum = sum_c;
                n_row_sum = sum_r;
                n_count   = cnt;
                if (wrap) begin
                    n_column = '0;
                    if (r_row != RW'(MAX_HEIGHT - 1)) begin
                        n_row = r_row + RW'(1);
                    end
                end else begin
                    n_column = r_column + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width   <= fcf_pkg::WIDTH_RESET;
            r_column  <= '0;
            r_row     <= '0;
            r_col_sum <= '0;
            r_row_sum <= '0;
            r_count   <= '0;
        end else begin
            if (i_cfg_we) begin
                r_width <= i_cfg_wdata;
            end
            r_column  <= n_column;
            r_row     <= n_row;
            r_col_sum <= n_col_sum;
            r_row_sum <= n_row_sum;
            r_count   <= n_count;
        end
    end

endmodule

// File: design/fcf_queue.sv
// Short queue of frame totals between the accumulator and the divider.
// Depends on fcf_pkg for the entry type and depth.
module fcf_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  fcf_pkg::t_frame_sums i_push_data,
    input  logic                 i_pop,
    output fcf_pkg::t_frame_sums o_head,
    output fcf_pkg::t_q_status   o_status
);

    localparam int DEPTH = fcf_pkg::QUEUE_DEPTH;
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FW    = $clog2(DEPTH + 1);

    fcf_pkg::t_frame_sums r_mem [DEPTH];
    logic [PW-1:0]        r_wr_ptr;
    logic [PW-1:0]        r_rd_ptr;
    logic [FW-1:0]        r_fill;

    function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    assign o_head             = r_mem[r_rd_ptr];
    assign o_status.full      = (r_fill == FW'(DEPTH));
    assign o_status.not_empty = (r_fill != '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_next(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_next(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_fill <= r_fill + FW'(1);
            end else if (i_pop && !i_push) begin
                r_fill <= r_fill - FW'(1);
            end
        end
    end

endmodule

// File: design/fcf_back.sv
// Back end: divides both frame sums by the count, one quotient bit a cycle,
// and holds the result in an output register. Depends on fcf_pkg.
module fcf_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_not_empty,
    input  fcf_pkg::t_frame_sums          i_head,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [fcf_pkg::COORD_W-1:0]   o_center_x,
    output logic [fcf_pkg::COORD_W-1:0]   o_center_y,
    output logic [fcf_pkg::COUNT_W-1:0]   o_pixel_count,
    output logic                          o_found
);

    localparam int DW  = fcf_pkg::DIV_STEPS;
    localparam int NW  = fcf_pkg::COUNT_W;
    localparam int XW  = fcf_pkg::COORD_W;
    localparam int SCW = $clog2(fcf_pkg::DIV_STEPS);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]     r_state, n_state;
    logic [SCW-1:0] r_step, n_step;
    logic [DW-1:0]  r_dvd_x, n_dvd_x;
    logic [DW-1:0]  r_dvd_y, n_dvd_y;
    logic [NW-1:0]  r_rem_x, n_rem_x;
    logic [NW-1:0]  r_rem_y, n_rem_y;
    logic [NW-1:0]  r_div, n_div;
    logic           r_out_valid, n_out_valid;
    logic [XW-1:0]  r_cx;
    logic [XW-1:0]  r_cy;
    logic [NW-1:0]  r_cnt;
    logic           r_found;
    logic           out_load;

    // restoring division step: returns {remainder, shifted dividend with quotient bit}
    function automatic logic [NW+DW-1:0] div_step(input logic [DW-1:0] dvd,
                                                  input logic [NW-1:0] rem,
                                                  input logic [NW-1:0] d);
        logic [NW:0] sh;
        logic [NW:0] diff;
        logic        ge;
        sh   = {rem, dvd[DW-1]};
        diff = sh - {1'b0, d};
        ge   = sh >= {1'b0, d};
        if (ge) begin
            return {diff[NW-1:0], dvd[DW-2:0], 1'b1};
        end
        return {sh[NW-1:0], dvd[DW-2:0], 1'b0};
    endfunction

    assign out_load = (r_state == S_DONE) && (!r_out_valid || i_ready);
    assign o_pop    = (r_state == S_IDLE) && i_q_not_empty;

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_dvd_x     = r_dvd_x;
        n_dvd_y     = r_dvd_y;
        n_rem_x     = r_rem_x;
        n_rem_y     = r_rem_y;
        n_div       = r_div;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_q_not_empty) begin
                    // add half the count so the quotient rounds half up
                    n_dvd_x = {1'b0, i_head.col_sum} + DW'(i_head.count >> 1);
                    n_dvd_y = {1'b0, i_head.row_sum} + DW'(i_head.count >> 1);
                    n_rem_x = '0;
                    n_rem_y = '0;
                    n_div   = i_head.count;
                    n_step  = '0;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                {n_rem_x, n_dvd_x} = div_step(r_dvd_x, r_rem_x, r_div);
                {n_rem_y, n_dvd_y} = div_step(r_dvd_y, r_rem_y, r_div);
                if (r_step == SCW'(DW - 1)) begin
                    n_state = S_DONE;
                end else begin
                    n_step = r_step + SCW'(1);
                end
            end
            S_DONE: begin
                if (out_load) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dvd_x <= n_dvd_x;
        r_dvd_y <= n_dvd_y;
        r_rem_x <= n_rem_x;
        r_rem_y <= n_rem_y;
        r_div   <= n_div;
        if (out_load) begin
            // an empty frame reports the origin
            r_cx    <= (r_div != '0) ? r_dvd_x[XW-1:0] : '0;
            r_cy    <= (r_div != '0) ? r_dvd_y[XW-1:0] : '0;
            r_cnt   <= r_div;
            r_found <= (r_div != '0);
        end
    end

    assign o_valid       = r_out_valid;
    assign o_center_x    = r_cx;
    assign o_center_y    = r_cy;
    assign o_pixel_count = r_cnt;
    assign o_found       = r_found;

endmodule

// File: design/foreground_centroid_finder_unit.sv
// Foreground centroid finder: takes one grayscale pixel per cycle in raster order
// (any value other than 0xFF counts as foreground) and, on the pixel flagged last,
// gives the rounded mean column and row, the foreground count and a found flag.
// Pixels are accepted at one per cycle; o_ready drops only while the two-entry
// queue of frame totals is full. When the divider is free, each frame's totals are
// loaded from the queue into the bit-serial divider, which computes one quotient bit
// per cycle for both coordinates side by side, and the result then goes into the
// output register. Frames shorter than the divider's run back up into the
// queue and then stall the input. image_width is written through i_cfg_we and
// i_cfg_wdata; 0 acts as 1 and values above MAX_WIDTH act as MAX_WIDTH.
// Depends on fcf_pkg, fcf_front, fcf_queue and fcf_back.
module foreground_centroid_finder_unit #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [fcf_pkg::CFG_W-1:0]           i_cfg_wdata,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [fcf_pkg::PIX_W-1:0]           i_pixel_value,
    input  logic                                i_last_pixel,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [fcf_pkg::COORD_W-1:0]         o_center_x,
    output logic [fcf_pkg::COORD_W-1:0]         o_center_y,
    output logic [fcf_pkg::COUNT_W-1:0]         o_pixel_count,
    output logic                                o_found
);

    logic                 w_push;
    fcf_pkg::t_frame_sums w_push_data;
    logic                 w_pop;
    fcf_pkg::t_frame_sums w_head;
    fcf_pkg::t_q_status   w_q_status;

    fcf_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_pixel_value (i_pixel_value),
        .i_last_pixel  (i_last_pixel),
        .i_q_full      (w_q_status.full),
        .o_push        (w_push),
        .o_push_data   (w_push_data)
    );

    fcf_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_data),
        .i_pop       (w_pop),
        .o_head      (w_head),
        .o_status    (w_q_status)
    );

    fcf_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_not_empty (w_q_status.not_empty),
        .i_head        (w_head),
        .o_pop         (w_pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_center_x    (o_center_x),
        .o_center_y    (o_center_y),
        .o_pixel_count (o_pixel_count),
        .o_found       (o_found)
    );

endmodule

// File: design/fcf_checker.sv
// Port-level checks of the foreground centroid finder, bound to the top level.
// Depends on fcf_pkg and foreground_centroid_finder_unit.
module fcf_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_valid,
    input logic                          i_ready,
    input logic [fcf_pkg::COORD_W-1:0]   o_center_x,
    input logic [fcf_pkg::COORD_W-1:0]   o_center_y,
    input logic [fcf_pkg::COUNT_W-1:0]   o_pixel_count,
    input logic                          o_found
);

    // a held word keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_center_x) && $stable(o_center_y)
            && $stable(o_pixel_count) && $stable(o_found))
        else $error("result word changed while stalled");

    a_found_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_found == (o_pixel_count != '0)))
        else $error("found flag disagrees with pixel count");

    a_empty_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_found |-> (o_center_x == '0) && (o_center_y == '0))
        else $error("empty frame reported a nonzero centre");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result offered straight after reset");

endmodule

bind foreground_centroid_finder_unit fcf_checker u_fcf_checker (.*);

// File: verif/foreground_centroid_finder_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of foreground_centroid_finder_unit: streams grayscale frames,
// predicts each frame's centroid, count and found flag, and checks every output word.
// Depends on fcf_pkg and the design files of the block.
module foreground_centroid_finder_unit_tb;

    localparam int MAX_W         = 1024;
    localparam int MAX_H         = 1024;
    localparam int SETTLE_CYC    = 60;
    localparam int CYCLE_LIMIT   = 10_000_000;
    localparam int RANDOM_PIXELS = 480;
    localparam int RANDOM_FRAMES = 40;

    localparam int PIX_W   = fcf_pkg::PIX_W;
    localparam int CFG_W   = fcf_pkg::CFG_W;
    localparam int COORD_W = fcf_pkg::COORD_W;
    localparam int SUM_W   = fcf_pkg::SUM_W;
    localparam int COUNT_W = fcf_pkg::COUNT_W;

    localparam logic [PIX_W-1:0]   BACKGROUND  = fcf_pkg::BACKGROUND;
    localparam logic [COUNT_W-1:0] COUNT_MAX   = fcf_pkg::COUNT_MAX;
    localparam logic [CFG_W-1:0]   WIDTH_RESET = fcf_pkg::WIDTH_RESET;

    typedef struct {
        logic [COORD_W-1:0] cx;
        logic [COORD_W-1:0] cy;
        logic [COUNT_W-1:0] count;
        logic               found;
    } t_centroid;

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               i_cfg_we      = 1'b0;
    logic [CFG_W-1:0]   i_cfg_wdata   = '0;
    logic               i_valid       = 1'b0;
    logic               o_ready;
    logic [PIX_W-1:0]   i_pixel_value = '0;
    logic               i_last_pixel  = 1'b0;
    logic               o_valid;
    logic               i_ready       = 1'b0;
    logic [COORD_W-1:0] o_center_x;
    logic [COORD_W-1:0] o_center_y;
    logic [COUNT_W-1:0] o_pixel_count;
    logic               o_found;

    // frame accumulators of the predictor
    logic [CFG_W-1:0]   width_reg;
    logic [COORD_W-1:0] col_pos;
    logic [COORD_W-1:0] row_pos;
    logic [SUM_W-1:0]   col_acc;
    logic [SUM_W-1:0]   row_acc;
    logic [COUNT_W-1:0] fg_count;
    t_centroid          centroid_q[$];

    bit                 send_idle    = 1'b1;
    bit                 recv_idle    = 1'b1;
    int                 recv_wait    = 0;
    int                 errors       = 0;
    int                 pixels_sent  = 0;
    int                 frames_sent  = 0;
    int                 width_writes = 0;
    int                 results_seen = 0;
    longint unsigned    cycles       = 0;

    foreground_centroid_finder_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_pixel_value (i_pixel_value),
        .i_last_pixel  (i_last_pixel),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_center_x    (o_center_x),
        .o_center_y    (o_center_y),
        .o_pixel_count (o_pixel_count),
        .o_found       (o_found)
    );

    always begin
        #10;
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic int unsigned active_width(input logic [CFG_W-1:0] w);
        if (w == '0)
            return 1;
        if (w > MAX_W)
            return MAX_W;
        return 32'(w);
    endfunction

    task automatic clear_frame_sums();
        col_pos  = '0;
        row_pos  = '0;
        col_acc  = '0;
        row_acc  = '0;
        fg_count = '0;
    endtask

    task automatic predict_pixel(input logic [PIX_W-1:0] pix, input logic last);
        longint unsigned n;
        longint unsigned q;
        t_centroid       res;
        // a full count freezes the sums as well
        if (pix != BACKGROUND && fg_count != COUNT_MAX) begin
            col_acc  = col_acc + SUM_W'(col_pos);
            row_acc  = row_acc + SUM_W'(row_pos);
            fg_count = fg_count + 1'b1;
        end
        if (last) begin
            n         = 64'(fg_count);
            res.count = fg_count;
            res.found = (fg_count != '0);
            res.cx    = '0;
            res.cy    = '0;
            if (n != 0) begin
                q      = (64'(col_acc) + n / 2) / n;
                res.cx = q[COORD_W-1:0];
                q      = (64'(row_acc) + n / 2) / n;
                res.cy = q[COORD_W-1:0];
            end
            centroid_q.push_back(res);
            frames_sent++;
            clear_frame_sums();
        end else if (32'(col_pos) + 32'd1 >= active_width(width_reg)) begin
            col_pos = '0;
            if (row_pos < MAX_H - 1)
                row_pos = row_pos + 1'b1;
        end else begin
            col_pos = col_pos + 1'b1;
        end
    endtask

    // hold the word until the block takes it, then predict
    task automatic push_pixel(input logic [PIX_W-1:0] pix, input logic last);
        int gap;
        gap = send_idle ? $urandom_range(0, 9) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_pixel_value <= pix;
        i_last_pixel  <= last;
        do @(posedge i_clk); while (!o_ready);
        predict_pixel(pix, last);
        pixels_sent++;
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        while (centroid_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic write_width(input logic [CFG_W-1:0] value);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we  <= 1'b0;
        width_reg = value;
        width_writes++;
    endtask

    always @(posedge i_clk) begin : result_check
        t_centroid exp_res;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                results_seen++;
                if (centroid_q.size() == 0) begin
                    $error("result word with no frame pending");
                    errors++;
                end else begin
                    exp_res = centroid_q.pop_front();
                    if (o_center_x !== exp_res.cx) begin
                        $error("center_x: expected %0d, got %0d", exp_res.cx, o_center_x);
                        errors++;
                    end
                    if (o_center_y !== exp_res.cy) begin
                        $error("center_y: expected %0d, got %0d", exp_res.cy, o_center_y);
                        errors++;
                    end
                    if (o_pixel_count !== exp_res.count) begin
                        $error("pixel_count: expected %0d, got %0d",
                               exp_res.count, o_pixel_count);
                        errors++;
                    end
                    if (o_found !== exp_res.found) begin
                        $error("found: expected %0d, got %0d", exp_res.found, o_found);
                        errors++;
                    end
                end
                recv_wait = recv_idle ? $urandom_range(0, 9) : 0;
            end else if (recv_wait > 0) begin
                recv_wait--;
            end
            i_ready <= (recv_wait == 0);
        end
    end

    // default width of 640: foreground either side of the first wrap
    task automatic test_reset_width();
        logic [PIX_W-1:0] pix;
        for (int i = 0; i < 645; i++) begin
            pix = (i == 0 || i >= 638) ? PIX_W'($urandom_range(0, 254)) : BACKGROUND;
            push_pixel(pix, i == 644);
        end
    endtask

    task automatic test_frame_shapes();
        write_width(11'd4);
        push_pixel(BACKGROUND, 1'b1);           // empty frame
        push_pixel(8'h00, 1'b1);                // lone foreground pixel
        push_pixel(8'h00, 1'b0);
        push_pixel(8'hFE, 1'b0);
        push_pixel(BACKGROUND, 1'b0);
        push_pixel(8'h80, 1'b0);
        push_pixel(8'h01, 1'b0);
        push_pixel(BACKGROUND, 1'b1);
        push_pixel(8'h00, 1'b0);                // mean column of one half rounds up
        push_pixel(8'h00, 1'b1);
    endtask

    task automatic test_width_extremes();
        write_width(11'd0);                     // acts as one column
        push_pixel(8'h00, 1'b0);
        push_pixel(8'h7F, 1'b0);
        push_pixel(8'h01, 1'b1);
        write_width(11'd1);
        push_pixel(8'h10, 1'b0);
        push_pixel(8'h20, 1'b1);
        write_width(11'd1024);
        push_pixel(BACKGROUND, 1'b0);
        push_pixel(8'h40, 1'b1);
    endtask

    task automatic test_width_change_mid_frame();
        write_width(11'd3);
        for (int i = 0; i < 5; i++)
            push_pixel(PIX_W'($urandom_range(0, 254)), 1'b0);
        write_width(11'd2);
        for (int i = 0; i < 3; i++)
            push_pixel(PIX_W'($urandom_range(0, 254)), i == 2);
    endtask

    task automatic test_random_frames();
        logic [CFG_W-1:0] widths [13] = '{11'd1, 11'd2, 11'd3, 11'd5, 11'd8, 11'd13,
                                          11'd31, 11'd640, 11'd1023, 11'd1024,
                                          11'd0, 11'd1025, 11'd2047};
        logic [PIX_W-1:0] pix;
        int               first_pixel;
        int               first_frame;
        int               len;
        int               pct;
        int               pick;
        first_pixel = pixels_sent;
        first_frame = frames_sent;
        while (pixels_sent - first_pixel < RANDOM_PIXELS ||
               frames_sent - first_frame < RANDOM_FRAMES) begin
            if ($urandom_range(0, 3) == 0) begin
                send_idle = ($urandom_range(0, 2) != 0);
                recv_idle = ($urandom_range(0, 2) != 0);
                pick      = $urandom_range(0, 15);
                write_width(pick < 13 ? widths[pick] : CFG_W'($urandom_range(1, 64)));
            end
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 80) : $urandom_range(1, 16);
            pct = $urandom_range(0, 100);
            for (int i = 0; i < len; i++) begin
                if ($urandom_range(0, 99) >= pct)
                    pix = BACKGROUND;
                else if ($urandom_range(0, 7) == 0)
                    pix = $urandom_range(0, 1) ? 8'hFE : 8'h00;
                else
                    pix = PIX_W'($urandom_range(0, 254));
                push_pixel(pix, i == len - 1);
            end
        end
        send_idle = 1'b1;
        recv_idle = 1'b1;
    endtask

    initial begin
        width_reg = WIDTH_RESET;
        clear_frame_sums();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_width();
        test_frame_shapes();
        test_width_extremes();
        test_width_change_mid_frame();
        test_random_frames();
        drain_results();

        $display("Checked %0d centroid words from %0d pixels over %0d width writes",
                 results_seen, pixels_sent, width_writes);
        $display("Covered empty frames, widths 0 to 2047, a mid-frame width change, %s",
                 "rounding and stalls on both sides");
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
